>>> src/s2e_pkg.sv
// Shared types and constants for the Shift_JIS to EUC-JP byte converter.
package s2e_pkg;

    // Depth of the job queue between the front and back parts
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Byte codes
    localparam logic [7:0] SS2      = 8'h8E;
    localparam logic [7:0] HIGH_BIT = 8'h80;

    // One converted input: up to four bytes, the number used, and the end-of-stream mark
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
    } t_job;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> src/s2e_front.sv
// Front part: accepts source bytes, holds a pending lead byte, builds output jobs.
module s2e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    output logic            o_q_push,
    output s2e_pkg::t_job   o_q_job
);

    logic       r_lead_pend;
    logic       n_lead_pend;
    logic [7:0] r_lead_val;

    logic        w_trail;
    logic        w_lead;
    logic [15:0] w_jis;
    logic [1:0][7:0] w_a_bytes;
    logic [1:0][7:0] w_b_bytes;
    logic [2:0]  w_a_n;
    logic [2:0]  w_b_n;
    logic        w_store;

    function automatic logic is_lead(input logic [7:0] b);
        logic [7:0] x;
        x = b ^ 8'h20;
        return (x >= 8'hA1) && (x <= 8'hDC);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= 8'h40) && (b <= 8'hFC) && (b != 8'h7F);
    endfunction

    // Move the IBM extension area onto the NEC-selected codes
    function automatic logic [15:0] remap_ibm(input logic [15:0] w);
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] r;
        h = w[15:8];
        l = w[7:0];
        r = w;
        if (h == 8'hFA || h == 8'hFB || (h == 8'hFC && l <= 8'h4B)) begin
            if (w <= 16'hFA49)      r = w - 16'h0B51;
            else if (w <= 16'hFA53) r = w - 16'h72F6;
            else if (w <= 16'hFA57) r = w - 16'h0B5B;
            else if (w == 16'hFA58) r = 16'h878A;
            else if (w == 16'hFA59) r = 16'h8782;
            else if (w == 16'hFA5A) r = 16'h8784;
            else if (w == 16'hFA5B) r = 16'h879A;
            else if (w <= 16'hFA7E) r = w - 16'h0D1C;
            else if (w <= 16'hFA9B) r = w - 16'h0D1D;
            else if (w <= 16'hFAFC) r = w - 16'h0D1C;
            else if (w <= 16'hFB5B) r = w - 16'h0D5F;
            else if (w <= 16'hFB7E) r = w - 16'h0D1C;
            else if (w <= 16'hFB9B) r = w - 16'h0D1D;
            else if (w <= 16'hFBFC) r = w - 16'h0D1C;
            else                    r = w - 16'h0D5F;
        end
        return r;
    endfunction

    // Pair to JIS X 0208 row and column; zero when no valid code results
    function automatic logic [15:0] to_jis(input logic [7:0] lead, input logic [7:0] trail);
        logic [15:0] w;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [7:0]  hh;
        logic [8:0]  row;
        logic [7:0]  col;
        logic [15:0] r;
        w = remap_ibm({lead, trail});
        h = w[15:8];
        l = w[7:0];
        hh = h - ((h >= 8'hA0) ? 8'hC1 : 8'h81);
        if (l >= 8'h9F) begin
            row = {hh, 1'b0} + 9'h022;
            col = l - 8'h7E;
        end else begin
            row = {hh, 1'b0} + 9'h021;
            col = l - ((l <= 8'h7E) ? 8'h1F : 8'h20);
        end
        r = '0;
        if (is_lead(h) && is_trail(l) && row >= 9'h021 && row <= 9'h07E
            && col >= 8'h21 && col <= 8'h7E) begin
            r = {row[7:0], col};
        end
        return r;
    endfunction

    assign w_trail = is_trail(i_in_byte);
    assign w_lead  = is_lead(i_in_byte);
    assign w_jis   = to_jis(r_lead_val, i_in_byte);

    // Classify the beat against the held lead and gather its bytes
    always_comb begin
        w_a_bytes   = '0;
        w_b_bytes   = '0;
        w_a_n       = 3'd0;
        w_b_n       = 3'd0;
        w_store     = 1'b0;
        n_lead_pend = r_lead_pend;
        if (r_lead_pend) begin
            w_a_n = 3'd2;
            if (w_trail) begin
                if (w_jis != 16'h0000) begin
                    w_a_bytes[0] = s2e_pkg::HIGH_BIT | w_jis[15:8];
                    w_a_bytes[1] = s2e_pkg::HIGH_BIT | w_jis[7:0];
                end else begin
                    w_a_bytes[0] = r_lead_val;
                    w_a_bytes[1] = i_in_byte;
                end
            end else begin
                w_a_bytes[0] = s2e_pkg::SS2;
                w_a_bytes[1] = r_lead_val;
            end
        end
        if (!(r_lead_pend && w_trail)) begin
            if (w_lead && !i_in_last) begin
                w_store = 1'b1;
            end else if (i_in_byte >= s2e_pkg::HIGH_BIT) begin
                w_b_n        = 3'd2;
                w_b_bytes[0] = s2e_pkg::SS2;
                w_b_bytes[1] = i_in_byte;
            end else begin
                w_b_n        = 3'd1;
                w_b_bytes[0] = i_in_byte;
            end
        end
        if (i_accept) begin
            n_lead_pend = w_store;
        end
    end

    // Place the second group after the first
    always_comb begin
        o_q_job      = '0;
        o_q_job.cnt  = w_a_n + w_b_n;
        o_q_job.last = i_in_last;
        if (w_a_n != 3'd0) begin
            o_q_job.bytes[0] = w_a_bytes[0];
            o_q_job.bytes[1] = w_a_bytes[1];
            o_q_job.bytes[2] = w_b_bytes[0];
            o_q_job.bytes[3] = w_b_bytes[1];
        end else begin
            o_q_job.bytes[0] = w_b_bytes[0];
            o_q_job.bytes[1] = w_b_bytes[1];
        end
    end

    assign o_q_push = i_accept && (o_q_job.cnt != 3'd0);

    // Hold the pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pend <= 1'b0;
        end else begin
            r_lead_pend <= n_lead_pend;
        end
    end

    // Hold the lead byte value
    always_ff @(posedge i_clk) begin
        if (i_accept && w_store) begin
            r_lead_val <= i_in_byte;
        end
    end

endmodule

>>> src/s2e_queue.sv
// Short job queue between the front and back parts.
module s2e_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  s2e_pkg::t_job     i_job,
    input  logic              i_pop,
    output s2e_pkg::t_job     o_head,
    output s2e_pkg::t_q_stat  o_stat
);

    s2e_pkg::t_job                r_mem [s2e_pkg::QDEPTH];
    logic [s2e_pkg::QAW-1:0]      r_wp;
    logic [s2e_pkg::QAW-1:0]      r_rp;
    logic [s2e_pkg::QAW:0]        r_cnt;

    assign o_stat.full  = (r_cnt == (s2e_pkg::QAW+1)'(s2e_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    // Store a pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/s2e_back.sv
// Back part: takes jobs from the queue and hands out their bytes one beat at a time.
module s2e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s2e_pkg::t_job     i_head,
    input  s2e_pkg::t_q_stat  i_stat,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_stream_end
);

    s2e_pkg::t_job r_job;
    logic [1:0]    r_idx;
    logic          r_busy;

    logic w_final;
    logic w_beat;
    logic w_load;

    assign w_final = ({1'b0, r_idx} == (r_job.cnt - 3'd1));
    assign w_beat  = i_pop && r_busy;
    assign w_load  = !i_stat.empty && (!r_busy || (w_beat && w_final));
    assign o_q_pop = w_load;

    assign o_empty      = !r_busy;
    assign o_out_byte   = r_job.bytes[r_idx];
    assign o_run_last   = w_final;
    assign o_stream_end = w_final && r_job.last;

    // Step through the current job, load the next one when it is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_beat) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Hold the job payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_head;
        end
    end

endmodule

>>> src/sjis_to_eucjp_byte_converter_top.sv
// Top level of the Shift_JIS to EUC-JP byte converter.
//
//  channel   handshake            beat payload
//  source    push / full          i_in_byte, i_in_last
//  result    pop / empty          o_out_byte, o_run_last, o_stream_end
//
// A source byte is taken every cycle while the four-entry job queue has room.
// Each source byte yields zero to four result bytes; the back part hands out
// one result byte per cycle while pop is high.
// A job is first written into the queue, then loaded into the back part's
// job register when that part is idle, putting its first byte on the ports.
// Reset clears the held lead, the queue and the result stage; full stays high
// only while the queue is full, and a stalled result holds its bytes.
module sjis_to_eucjp_byte_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end
);

    s2e_pkg::t_job    w_q_job;
    s2e_pkg::t_job    w_head;
    s2e_pkg::t_q_stat w_q_stat;
    logic             w_accept;
    logic             w_q_push;
    logic             w_q_pop;

    assign full     = w_q_stat.full;
    assign w_accept = push && !w_q_stat.full;

    s2e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_q_push  (w_q_push),
        .o_q_job   (w_q_job)
    );

    s2e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_job),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    s2e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_stat       (w_q_stat),
        .o_q_pop      (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    // Never write a job into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_stat.full)
        else $error("job pushed into full queue");

    // Never take a job from an empty queue
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_stat.empty)
        else $error("job taken from empty queue");

    // A queued job always carries at least one byte
    a_job_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_stat.empty |-> (w_head.cnt != 3'd0 && w_head.cnt <= 3'd4))
        else $error("queued job with bad byte count");

    // Stream end only on the last byte of a job
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> o_run_last)
        else $error("stream end without run end");

endmodule
